[rtl/core/kwlex_pkg.sv]
// ----------------------------------------------------------------------------
// kwlex_pkg: shared types and constants for the keyword token lexer
// Holds the transaction structs for both channels, the token kinds, the
// keyword table and the byte class helpers.
// ----------------------------------------------------------------------------
package kwlex_pkg;

	// Width of the byte position counters (8..32)
	localparam int POSITION_BITS = 16;
	localparam int NUM_KW        = 9;
	localparam int KW_CHARS      = 8;

	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
	localparam logic [15:0]              LINE_MAX = 16'hFFFF;

	// Special bytes
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_COLON      = 8'h3A;
	localparam logic [7:0] CH_QUOTE      = 8'h22;
	localparam logic [7:0] CH_NEWLINE    = 8'h0A;
	localparam logic [7:0] CH_SPACE      = 8'h20;

	typedef enum logic [2:0] {
		KIND_KEYWORD    = 3'd0,
		KIND_IDENTIFIER = 3'd1,
		KIND_NUMBER     = 3'd2,
		KIND_STRING     = 3'd3,
		KIND_OPERATOR   = 3'd4,
		KIND_COLON      = 3'd5,
		KIND_END        = 3'd6
	} tok_kind_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_source;
	} src_item_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [3:0]  keyword_index;
		logic [15:0] start_offset;
		logic [15:0] lexeme_length;
		logic [15:0] line_number;
		logic        last_of_run;
	} tok_item_t;

	// Keyword table: val var loop truths proofs dg dgvec bool types
	localparam logic [7:0] KW_TEXT [NUM_KW][KW_CHARS] = '{
		'{"v", "a", "l", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"l", "o", "o", "p", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"t", "r", "u", "t", "h", "s", 8'h00, 8'h00},
		'{"p", "r", "o", "o", "f", "s", 8'h00, 8'h00},
		'{"d", "g", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"d", "g", "v", "e", "c", 8'h00, 8'h00, 8'h00},
		'{"b", "o", "o", "l", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"t", "y", "p", "e", "s", 8'h00, 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{
		3'd3, 3'd3, 3'd4, 3'd6, 3'd6, 3'd2, 3'd5, 3'd4, 3'd5
	};

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// Saturating increment of a position
	function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] p);
		return (p == POS_MAX) ? p : p + POSITION_BITS'(1);
	endfunction

	// Position to 16-bit output field (zero extend or keep low bits)
	function automatic logic [15:0] to16(input logic [POSITION_BITS-1:0] p);
		logic [31:0] w;
		w = 32'(p);
		return w[15:0];
	endfunction

endpackage

[rtl/core/keyword_token_lexer_top.sv]
// ----------------------------------------------------------------------------
// keyword_token_lexer_top: streaming keyword tokenizer
// Source bytes go in on the src channel, one per transaction; tokens come out
// on the tok channel, one per transaction. A transaction moves when valid is
// high and stall is low at a rising edge of clk.
// A src transaction with end_of_source set flushes a pending word, number or
// string and then gives an end token; the lexer then starts a new source at
// offset 0 on line 1. A byte gives zero, one or two tokens; last_of_run marks
// the final token caused by one src transaction.
// A byte is registered at the input, classified in the next cycle and its
// tokens are written into a four-entry output queue that drives tok; the
// write waits while the queue holds more than two tokens.
// Throughput: one byte per cycle while the queue holds at most two tokens;
// the tok port drains one token per cycle while tok_stall is low, so bytes
// that each give two tokens run at the output's rate.
// When the receiver stalls, the queue fills and src_stall rises; nothing is
// lost. Reset (arst_n low) empties the queue, clears the pending token, sets
// position to 0 and the line count to 1.
// ----------------------------------------------------------------------------
module keyword_token_lexer_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_stall,
	input  kwlex_pkg::src_item_t  src_item,
	output logic                  tok_valid,
	input  logic                  tok_stall,
	output kwlex_pkg::tok_item_t  tok_item
);

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WORD = 2'd1,
		MODE_NUM  = 2'd2,
		MODE_STR  = 2'd3
	} scan_mode_t;

	localparam int PB = kwlex_pkg::POSITION_BITS;

	// Input register
	logic                 valid_s1;
	kwlex_pkg::src_item_t item_s1;

	// Lexer state
	scan_mode_t                   mode_q;
	logic [PB-1:0]                pos_q;
	logic [PB-1:0]                start_q;
	logic [15:0]                  line_q;
	logic [kwlex_pkg::NUM_KW-1:0] alive_q;

	// Output queue
	kwlex_pkg::tok_item_t fifo_q [4];
	logic [1:0]           wr_ptr_q;
	logic [1:0]           rd_ptr_q;
	logic [2:0]           cnt_q;

	logic advance;
	logic pop;

	// Next-state and result logic
	scan_mode_t                   mode_d;
	logic [PB-1:0]                pos_d;
	logic [PB-1:0]                start_d;
	logic [15:0]                  line_d;
	logic [kwlex_pkg::NUM_KW-1:0] alive_d;
	kwlex_pkg::tok_item_t         res0;
	kwlex_pkg::tok_item_t         res1;
	logic [1:0]                   n_res;

	assign advance   = valid_s1 && (cnt_q <= 3'd2);
	assign src_stall = valid_s1 && !advance;
	assign pop       = tok_valid && !tok_stall;
	assign tok_valid = (cnt_q != 3'd0);
	assign tok_item  = fifo_q[rd_ptr_q];

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			item_s1 <= src_item;
		end
	end

	// Classify the registered byte against the current lexer state
	always_comb begin
		logic [7:0]           c;
		logic                 eos;
		logic                 word_ch;
		logic                 cont;
		logic                 pend;
		logic                 do_flush;
		logic                 do_single;
		logic [PB-1:0]        idx;
		logic [PB-1:0]        len;
		kwlex_pkg::tok_item_t flush_tok;
		kwlex_pkg::tok_item_t single_tok;

		c       = item_s1.ch;
		eos     = item_s1.end_of_source;
		word_ch = kwlex_pkg::is_alpha(c) || kwlex_pkg::is_digit(c) ||
		          c == kwlex_pkg::CH_UNDERSCORE;
		cont    = (mode_q == MODE_STR) ||
		          (mode_q == MODE_WORD && word_ch) ||
		          (mode_q == MODE_NUM && kwlex_pkg::is_digit(c));
		pend    = (mode_q != MODE_IDLE);
		idx     = pos_q - start_q;
		len     = pos_q - start_q;

		// Pending token, as it would be flushed now
		flush_tok               = '0;
		flush_tok.start_offset  = kwlex_pkg::to16(start_q);
		flush_tok.lexeme_length = kwlex_pkg::to16(len);
		flush_tok.line_number   = line_q;
		unique case (mode_q)
			MODE_WORD: begin
				flush_tok.kind = kwlex_pkg::KIND_IDENTIFIER;
				for (int k = 0; k < kwlex_pkg::NUM_KW; k++) begin
					if (alive_q[k] && len == PB'(kwlex_pkg::KW_LEN[k])) begin
						flush_tok.kind          = kwlex_pkg::KIND_KEYWORD;
						flush_tok.keyword_index = 4'(k);
					end
				end
			end
			MODE_NUM:  flush_tok.kind = kwlex_pkg::KIND_NUMBER;
			MODE_STR:  flush_tok.kind = kwlex_pkg::KIND_STRING;
			MODE_IDLE: flush_tok.kind = kwlex_pkg::KIND_IDENTIFIER;
			default:   flush_tok.kind = kwlex_pkg::KIND_IDENTIFIER;
		endcase

		// One-byte token or end token
		single_tok             = '0;
		single_tok.start_offset = kwlex_pkg::to16(pos_q);
		single_tok.line_number = line_q;
		if (eos) begin
			single_tok.kind          = kwlex_pkg::KIND_END;
			single_tok.lexeme_length = 16'd0;
		end else if (c == kwlex_pkg::CH_COLON) begin
			single_tok.kind          = kwlex_pkg::KIND_COLON;
			single_tok.lexeme_length = 16'd1;
		end else begin
			single_tok.kind          = kwlex_pkg::KIND_OPERATOR;
			single_tok.lexeme_length = 16'd1;
		end

		do_flush  = eos ? pend :
		            (mode_q == MODE_STR) ? (c == kwlex_pkg::CH_QUOTE) : (!cont && pend);
		do_single = eos || (!cont && !kwlex_pkg::is_space(c) && !kwlex_pkg::is_alpha(c) &&
		            !kwlex_pkg::is_digit(c) && c != kwlex_pkg::CH_QUOTE);

		// Pack results in order, mark the last
		res0  = do_flush ? flush_tok : single_tok;
		res1  = single_tok;
		n_res = 2'(do_flush) + 2'(do_single);
		if (n_res == 2'd1) begin
			res0.last_of_run = 1'b1;
		end
		res1.last_of_run = 1'b1;

		// Next state
		mode_d  = mode_q;
		pos_d   = kwlex_pkg::sat_inc(pos_q);
		start_d = start_q;
		line_d  = line_q;
		alive_d = alive_q;
		if (eos) begin
			mode_d  = MODE_IDLE;
			pos_d   = '0;
			start_d = '0;
			line_d  = 16'd1;
			alive_d = '0;
		end else if (mode_q == MODE_STR) begin
			if (c == kwlex_pkg::CH_QUOTE) begin
				mode_d = MODE_IDLE;
			end
		end else if (cont) begin
			// Word or number goes on; words narrow the keyword candidates
			if (mode_q == MODE_WORD) begin
				for (int k = 0; k < kwlex_pkg::NUM_KW; k++) begin
					if (pos_q == kwlex_pkg::POS_MAX || idx >= PB'(kwlex_pkg::KW_LEN[k]) ||
					    kwlex_pkg::KW_TEXT[k][idx[2:0]] != c) begin
						alive_d[k] = 1'b0;
					end
				end
			end
		end else begin
			mode_d = MODE_IDLE;
			if (kwlex_pkg::is_space(c)) begin
				if (c == kwlex_pkg::CH_NEWLINE && line_q != kwlex_pkg::LINE_MAX) begin
					line_d = line_q + 16'd1;
				end
			end else if (kwlex_pkg::is_alpha(c)) begin
				mode_d  = MODE_WORD;
				start_d = pos_q;
				for (int k = 0; k < kwlex_pkg::NUM_KW; k++) begin
					alive_d[k] = (kwlex_pkg::KW_TEXT[k][0] == c);
				end
			end else if (kwlex_pkg::is_digit(c)) begin
				mode_d  = MODE_NUM;
				start_d = pos_q;
			end else if (c == kwlex_pkg::CH_QUOTE) begin
				mode_d  = MODE_STR;
				start_d = kwlex_pkg::sat_inc(pos_q);
			end
		end
	end

	// Lexer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			start_q <= '0;
			line_q  <= 16'd1;
			alive_q <= '0;
		end else if (advance) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			line_q  <= line_d;
			alive_q <= alive_d;
		end
	end

	// Output queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (advance) begin
				wr_ptr_q <= wr_ptr_q + n_res;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + (advance ? 3'(n_res) : 3'd0) - 3'(pop);
		end
	end

	// Output queue storage
	always_ff @(posedge clk) begin
		if (advance && n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (advance && n_res == 2'd2) begin
			fifo_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

endmodule

[rtl/core/kwlex_checker.sv]
// ----------------------------------------------------------------------------
// kwlex_checker: port-level checks for the keyword token lexer
// Watches the tok channel of the top level and flags malformed tokens.
// ----------------------------------------------------------------------------
module kwlex_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 tok_valid,
	input logic                 tok_stall,
	input kwlex_pkg::tok_item_t tok_item
);

	// A stalled token holds until taken
	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(tok_item))
		else $error("token changed while stalled");

	// End token closes the run and has no length
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_item.kind == kwlex_pkg::KIND_END |->
		tok_item.last_of_run && tok_item.lexeme_length == 16'd0)
		else $error("end token malformed");

	// Keyword index only on keyword tokens
	a_kw_index: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_item.kind != kwlex_pkg::KIND_KEYWORD |->
		tok_item.keyword_index == 4'd0)
		else $error("keyword index on non-keyword token");

	// Colon and operator tokens are one byte and end their run
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (tok_item.kind == kwlex_pkg::KIND_COLON ||
		tok_item.kind == kwlex_pkg::KIND_OPERATOR) |->
		tok_item.lexeme_length == 16'd1 && tok_item.last_of_run)
		else $error("one-byte token malformed");

endmodule

bind keyword_token_lexer_top kwlex_checker u_kwlex_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.tok_valid (tok_valid),
	.tok_stall (tok_stall),
	.tok_item  (tok_item)
);
